### src/act_pkg.sv
// shared types and constants for the collider table
package act_pkg;
	localparam int SLOTS_DEF = 16;
	localparam int QDEPTH = 2;

	typedef enum logic [2:0] {
		ACT_ADD    = 3'd0,
		ACT_MARK   = 3'd1,
		ACT_PURGE  = 3'd2,
		ACT_MOVE   = 3'd3,
		ACT_CHECK  = 3'd4,
		ACT_CLEAR  = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		RK_ADDED = 3'd0,
		RK_FULL  = 3'd1,
		RK_ACK   = 3'd2,
		RK_HIT   = 3'd3,
		RK_DONE  = 3'd4
	} kind_t;

	localparam logic [1:0] REG_LOW = 2'd0;
	localparam logic [1:0] REG_HIGH = 2'd1;
	localparam logic [1:0] REG_REV = 2'd2;

	typedef struct packed {
		logic [2:0]  action;
		logic [3:0]  slot;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [14:0] width;
		logic [14:0] height;
		logic [3:0]  collider_class;
		logic        has_handler;
	} item_t;

	typedef struct packed {
		logic [2:0] result_kind;
		logic [3:0] owner_slot;
		logic [3:0] other_slot;
		logic [3:0] owner_class;
		logic [3:0] other_class;
		logic       last;
	} result_t;

	// strict overlap in 18 bits signed, no wrap
	function automatic logic overlap(input logic [63:0] a, input logic [63:0] b);
		logic signed [17:0] ax, ay, aw, ah, bx, by, bw, bh;
		ax = 18'(signed'(a[15:0]));
		ay = 18'(signed'(a[31:16]));
		aw = {3'b0, a[46:32]};
		ah = {3'b0, a[62:48]};
		bx = 18'(signed'(b[15:0]));
		by = 18'(signed'(b[31:16]));
		bw = {3'b0, b[46:32]};
		bh = {3'b0, b[62:48]};
		return (ax < bx + bw) && (ax + aw > bx) && (ay < by + bh) && (ay + ah > by);
	endfunction

	function automatic logic reacts(input logic [80:0] m, input logic [3:0] r,
			input logic [3:0] c);
		logic [7:0] bitn;
		bitn = 8'(r) * 8'd9 + 8'(c);
		if (r > 4'd8 || c > 4'd8) return 1'b0;
		return m[bitn[6:0]];
	endfunction
endpackage

### src/act_stream_if.sv
// valid/ready channel carrying one payload
interface act_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/aabb_collision_table.sv
// top level: collider table with apb register port
// Usage: items enter on in_ch (valid/ready), results leave on out_ch.
// Each item is queued in a two-entry queue, then executed by the back end.
// Add, mark, purge, move, clear and unused actions give one result, valid
// in the cycle after the item leaves the queue. A row check on slot i scans
// slots i+1 to SLOTS-1, one slot per cycle while out_ch is not stalled,
// with a pass through the reverse state for each pair that hits both ways,
// then gives a row-done result with last set once slot SLOTS-1 is scanned.
// The next item leaves the queue once the last result is taken.
// The result register holds while out_ch is stalled; the scan holds with it,
// while the queue keeps taking items until full.
// Reset empties the table and queue and loads the reaction matrix and
// reverse enable to their defaults. Registers are written over APB at 8*i
// and should change only while the block is idle.
module aabb_collision_table import act_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	act_stream_if.sink   in_ch,
	act_stream_if.source out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	logic [62:0] low_q;
	logic [17:0] high_q;
	logic        rev_q;
	logic        q_valid, deq;
	item_t       q_item;
	logic [1:0]  ra;

	assign pready = 1'b1;
	assign ra = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= 63'd4922580132241672192;
			high_q <= 18'd36906;
			rev_q <= 1'b1;
		end else if (psel && penable && pwrite) begin
			unique case (ra)
				REG_LOW:  low_q <= pwdata[62:0];
				REG_HIGH: high_q <= pwdata[17:0];
				REG_REV:  rev_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ra)
			REG_LOW:  prdata = {1'b0, low_q};
			REG_HIGH: prdata = {46'd0, high_q};
			REG_REV:  prdata = {63'd0, rev_q};
			default:  prdata = '0;
		endcase
	end

	act_front u_front (.clk, .arst_n, .in(in_ch), .deq, .q_valid, .q_item);

	act_back #(.SLOTS(SLOTS)) u_back (.clk, .arst_n, .q_valid, .q_item, .deq,
		.react({high_q, low_q}), .rev_en(rev_q), .out(out_ch));
endmodule

### src/act_front.sv
// input side: takes items into a short queue
module act_front import act_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	act_stream_if.sink   in,
	input  logic         deq,
	output logic         q_valid,
	output item_t        q_item
);
	item_t      mem_q [QDEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       enq;

	assign in.ready = cnt_q != 2'(QDEPTH);
	assign enq = in.valid && in.ready;
	assign q_valid = cnt_q != 2'd0;
	assign q_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (enq) mem_q[wp_q] <= in.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (enq) wp_q <= ~wp_q;
			if (deq) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(enq) - 2'(deq);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(QDEPTH))
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) deq |-> q_valid)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) (cnt_q == 2'(QDEPTH)) |-> !in.ready)
		else $error("transfer into full queue");
endmodule

### src/act_back.sv
// execution side: table state, row scan and result register
module act_back import act_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        deq,
	input  logic [80:0] react,
	input  logic        rev_en,
	act_stream_if.source out
);
	localparam int IW = $clog2(SLOTS);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_REV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t        state_q;
	logic [SLOTS-1:0] valid_q, marked_q;
	logic [63:0]   rect_q [SLOTS];
	logic [3:0]    class_q [SLOTS];
	logic          hnd_q [SLOTS];
	logic [IW-1:0] row_q, k_q;
	logic [IW:0]   kn;
	logic          rev_pend_q;
	result_t       res_q;
	logic          res_v_q;
	logic          oslot;
	logic          hit_f, hit_r, ok;
	logic [IW-1:0] free_idx;
	logic          free_any;
	logic [63:0]   rect_in;
	logic          sv;
	logic [IW-1:0] slot_i;

	assign rect_in = {1'b0, q_item.height, 1'b0, q_item.width, q_item.pos_y, q_item.pos_x};
	assign oslot = !res_v_q || out.ready;
	assign out.valid = res_v_q;
	assign out.data = res_q;
	assign slot_i = IW'(q_item.slot);
	assign sv = (32'(q_item.slot) < SLOTS) && valid_q[slot_i];

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	assign ok = valid_q[k_q] && overlap(rect_q[row_q], rect_q[k_q]);
	assign hit_f = ok && hnd_q[row_q] && reacts(react, class_q[row_q], class_q[k_q]);
	assign hit_r = ok && rev_en && hnd_q[k_q] && reacts(react, class_q[k_q], class_q[row_q]);
	assign kn = {1'b0, k_q} + 1'b1;

	assign deq = q_valid && oslot && state_q == ST_IDLE;

	always_ff @(posedge clk) begin
		if (deq && q_item.action == ACT_ADD && free_any) begin
			rect_q[free_idx] <= rect_in;
			class_q[free_idx] <= q_item.collider_class;
			hnd_q[free_idx] <= q_item.has_handler;
		end
		if (deq && q_item.action == ACT_MOVE && sv) rect_q[slot_i] <= rect_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			marked_q <= '0;
			res_v_q <= 1'b0;
			res_q <= '0;
			row_q <= '0;
			k_q <= '0;
			rev_pend_q <= 1'b0;
		end else begin
			if (out.ready) res_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (deq) begin
					res_v_q <= 1'b1;
					res_q <= '{RK_ACK, 4'd0, 4'd0, 4'd0, 4'd0, 1'b1};
					case (q_item.action)
						ACT_ADD: if (free_any) begin
							valid_q[free_idx] <= 1'b1;
							marked_q[free_idx] <= 1'b0;
							res_q <= '{RK_ADDED, 4'(free_idx), 4'd0,
								q_item.collider_class, 4'd0, 1'b1};
						end else begin
							res_q <= '{RK_FULL, 4'd0, 4'd0, 4'd0, 4'd0, 1'b1};
						end
						ACT_MARK: if (sv) marked_q[slot_i] <= 1'b1;
						ACT_PURGE: begin
							valid_q <= valid_q & ~marked_q;
							marked_q <= '0;
						end
						ACT_CLEAR: begin
							valid_q <= '0;
							marked_q <= '0;
						end
						ACT_CHECK: begin
							res_q <= '{RK_DONE, q_item.slot, 4'd0, 4'd0, 4'd0, 1'b1};
							if (sv && 32'(q_item.slot) < SLOTS - 1) begin
								res_v_q <= 1'b0;
								row_q <= slot_i;
								k_q <= slot_i + 1'b1;
								state_q <= ST_SCAN;
							end
						end
						default: ;
					endcase
				end
				ST_SCAN: if (oslot) begin
					res_v_q <= 1'b0;
					if (hit_f) begin
						res_v_q <= 1'b1;
						res_q <= '{RK_HIT, 4'(row_q), 4'(k_q), class_q[row_q],
							class_q[k_q], 1'b0};
					end
					if (hit_f && hit_r) state_q <= ST_REV;
					else begin
						if (hit_r) begin
							res_v_q <= 1'b1;
							res_q <= '{RK_HIT, 4'(k_q), 4'(row_q), class_q[k_q],
								class_q[row_q], 1'b0};
						end
						if (32'(kn) >= SLOTS) state_q <= ST_DONE;
						else k_q <= kn[IW-1:0];
					end
				end
				ST_REV: if (oslot) begin
					res_v_q <= 1'b1;
					res_q <= '{RK_HIT, 4'(k_q), 4'(row_q), class_q[k_q],
						class_q[row_q], 1'b0};
					if (32'(kn) >= SLOTS) state_q <= ST_DONE;
					else begin
						k_q <= kn[IW-1:0];
						state_q <= ST_SCAN;
					end
				end
				ST_DONE: if (oslot) begin
					res_v_q <= 1'b1;
					res_q <= '{RK_DONE, 4'(row_q), 4'd0, 4'd0, 4'd0, 1'b1};
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) (res_v_q && !out.ready) |=> res_v_q)
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n) deq |-> state_q == ST_IDLE)
		else $error("dequeue during scan");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_REV) |-> k_q > row_q)
		else $error("scan index behind row");
	assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
endmodule
